@@ src/dar_pkg.sv @@
// ----------------------------------------------------------------------------
// dar_pkg: shared types and constants for the axis ramp core
// transfer payloads, register set, axis state and fixed scaling constants
// ----------------------------------------------------------------------------
package dar_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_RAMP_STEP         = 2'd0;
   localparam logic [1:0] CSR_STICK_DEADZONE    = 2'd1;
   localparam logic [1:0] CSR_TRIGGER_THRESHOLD = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   // register reset values
   localparam logic [7:0]  RAMP_STEP_RST         = 8'd20;
   localparam logic [14:0] STICK_DEADZONE_RST    = 15'd8000;
   localparam logic [14:0] TRIGGER_THRESHOLD_RST = 15'd2000;

   // axis constants
   localparam logic [9:0]  WHEEL_CENTRE = 10'h200;
   localparam logic [9:0]  AXIS_SPAN    = 10'h100;
   localparam logic [9:0]  WHEEL_MIN    = 10'h100;
   localparam logic [9:0]  WHEEL_MAX    = 10'h300;
   localparam logic [8:0]  PEDAL_MAX    = 9'h100;
   localparam logic [15:0] FULL_SCALE   = 16'd32767;

   // key_actions bit positions
   localparam int KEY_COIN    = 0;
   localparam int KEY_START   = 1;
   localparam int KEY_SERVICE = 2;
   localparam int KEY_TEST    = 3;
   localparam int KEY_LEFT    = 4;
   localparam int KEY_RIGHT   = 5;
   localparam int KEY_FWD     = 6;
   localparam int KEY_BWD     = 7;
   localparam int KEY_LTRIG   = 8;
   localparam int KEY_RTRIG   = 9;

   // pad_buttons bit positions
   localparam int PAD_START     = 0;
   localparam int PAD_A         = 1;
   localparam int PAD_Y         = 2;
   localparam int PAD_BACK      = 3;
   localparam int PAD_X         = 4;
   localparam int PAD_LSHOULDER = 5;
   localparam int PAD_B         = 6;
   localparam int PAD_RSHOULDER = 7;

   // func codes
   localparam logic FUNC_FRAME   = 1'b0;
   localparam logic FUNC_NEUTRAL = 1'b1;

   typedef struct packed {
      logic               func;
      logic [9:0]         key_actions;
      logic               pad_present;
      logic signed [15:0] stick_x;
      logic [14:0]        rtrig_level;
      logic [14:0]        ltrig_level;
      logic [7:0]         pad_buttons;
   } req_payload_type;

   typedef struct packed {
      logic [5:0] button_bits;
      logic [9:0] wheel_out;
      logic [8:0] pedal_fwd_out;
      logic [8:0] pedal_bwd_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  ramp_step;
      logic [14:0] stick_deadzone;
      logic [14:0] trigger_threshold;
   } cfg_type;

   typedef struct packed {
      logic [9:0] wheel;
      logic [8:0] fwd;
      logic [8:0] bwd;
   } axis_state_type;

endpackage

@@ src/dar_scale.sv @@
// ----------------------------------------------------------------------------
// dar_scale: reading times 256 over full scale
// floor(mag * 256 / 32767) for mag up to 32768, by shift and one correction
// ----------------------------------------------------------------------------
module dar_scale (
   input  logic [15:0] mag,
   output logic [8:0]  scaled
);
   import dar_pkg::*;

   logic [8:0]  quot_est;
   logic [15:0] rem_est;
   logic        carry;

   // 32767 = 2^15 - 1, so remainder of the shift estimate is low bits plus quotient
   assign quot_est = mag[15:7];
   assign rem_est  = {1'b0, mag[6:0], 8'd0} + {7'd0, quot_est};
   assign carry    = (rem_est >= FULL_SCALE);
   assign scaled   = quot_est + {8'd0, carry};

endmodule

@@ src/dar_axis_calc.sv @@
// ----------------------------------------------------------------------------
// dar_axis_calc: per-frame axis update
// key ramp, pad override, clamp, button merge and neutral reset for one item
// ----------------------------------------------------------------------------
module dar_axis_calc (
   input  dar_pkg::req_payload_type item,
   input  dar_pkg::cfg_type         cfg,
   input  dar_pkg::axis_state_type  state_cur,
   output dar_pkg::axis_state_type  state_next,
   output dar_pkg::rsp_payload_type result
);
   import dar_pkg::*;

   function automatic logic [9:0] move_toward(input logic [9:0] cur,
                                              input logic [9:0] goal,
                                              input logic [7:0] step);
      logic [9:0] res;
      begin
         res = cur;
         if (cur < goal) begin
            res = ((goal - cur) < {2'd0, step}) ? goal : cur + {2'd0, step};
         end else if (cur > goal) begin
            res = ((cur - goal) < {2'd0, step}) ? goal : cur - {2'd0, step};
         end
         move_toward = res;
      end
   endfunction

   logic [9:0]  wheel_goal;
   logic [9:0]  wheel_ramp;
   logic [9:0]  fwd_ramp;
   logic [9:0]  bwd_ramp;
   logic [15:0] stick_mag;
   logic [8:0]  stick_scaled;
   logic [8:0]  fwd_scaled;
   logic [8:0]  bwd_scaled;
   logic [9:0]  wheel_sel;
   logic [8:0]  fwd_sel;
   logic [8:0]  bwd_sel;
   logic [5:0]  buttons;
   logic [7:0]  pb;

   assign stick_mag = item.stick_x[15] ? (~item.stick_x + 16'd1) : item.stick_x;

   dar_scale u_scale_stick (.mag(stick_mag),                 .scaled(stick_scaled));
   dar_scale u_scale_fwd   (.mag({1'b0, item.rtrig_level}),  .scaled(fwd_scaled));
   dar_scale u_scale_bwd   (.mag({1'b0, item.ltrig_level}),  .scaled(bwd_scaled));

   always_comb begin
      wheel_goal = WHEEL_CENTRE;
      if (item.key_actions[KEY_RIGHT] && !item.key_actions[KEY_LEFT]) begin
         wheel_goal = WHEEL_CENTRE + AXIS_SPAN;
      end else if (item.key_actions[KEY_LEFT] && !item.key_actions[KEY_RIGHT]) begin
         wheel_goal = WHEEL_CENTRE - AXIS_SPAN;
      end

      wheel_ramp = move_toward(state_cur.wheel, wheel_goal, cfg.ramp_step);
      fwd_ramp   = move_toward({1'b0, state_cur.fwd},
                               item.key_actions[KEY_FWD] ? {1'b0, PEDAL_MAX} : 10'd0,
                               cfg.ramp_step);
      bwd_ramp   = move_toward({1'b0, state_cur.bwd},
                               item.key_actions[KEY_BWD] ? {1'b0, PEDAL_MAX} : 10'd0,
                               cfg.ramp_step);

      wheel_sel = wheel_ramp;
      fwd_sel   = fwd_ramp[8:0];
      bwd_sel   = bwd_ramp[8:0];

      buttons = {item.key_actions[KEY_RTRIG], item.key_actions[KEY_LTRIG],
                 item.key_actions[KEY_START], item.key_actions[KEY_TEST],
                 item.key_actions[KEY_SERVICE], item.key_actions[KEY_COIN]};
      pb = item.pad_buttons;

      if (item.pad_present) begin
         if (stick_mag > {1'b0, cfg.stick_deadzone}) begin
            wheel_sel = item.stick_x[15] ? WHEEL_CENTRE - {1'b0, stick_scaled}
                                         : WHEEL_CENTRE + {1'b0, stick_scaled};
         end
         if (item.rtrig_level > cfg.trigger_threshold) begin
            fwd_sel = fwd_scaled;
         end
         if (item.ltrig_level > cfg.trigger_threshold) begin
            bwd_sel = bwd_scaled;
         end
         buttons[3] = buttons[3] | pb[PAD_START] | pb[PAD_A] | pb[PAD_Y];
         buttons[0] = buttons[0] | pb[PAD_BACK];
         buttons[4] = buttons[4] | pb[PAD_X] | pb[PAD_LSHOULDER];
         buttons[5] = buttons[5] | pb[PAD_B] | pb[PAD_RSHOULDER];
      end

      if (wheel_sel < WHEEL_MIN) begin
         wheel_sel = WHEEL_MIN;
      end
      if (wheel_sel > WHEEL_MAX) begin
         wheel_sel = WHEEL_MAX;
      end
      if (fwd_sel > PEDAL_MAX) begin
         fwd_sel = PEDAL_MAX;
      end
      if (bwd_sel > PEDAL_MAX) begin
         bwd_sel = PEDAL_MAX;
      end

      if (item.func == FUNC_NEUTRAL) begin
         state_next.wheel = WHEEL_CENTRE;
         state_next.fwd   = 9'd0;
         state_next.bwd   = 9'd0;
         result.button_bits = 6'd0;
      end else begin
         state_next.wheel = wheel_sel;
         state_next.fwd   = fwd_sel;
         state_next.bwd   = bwd_sel;
         result.button_bits = buttons;
      end
      result.wheel_out     = state_next.wheel;
      result.pedal_fwd_out = state_next.fwd;
      result.pedal_bwd_out = state_next.bwd;
   end

endmodule

@@ src/dar_csr.sv @@
// ----------------------------------------------------------------------------
// dar_csr: configuration registers
// ramp step, stick deadzone and trigger threshold, written over the csr port
// ----------------------------------------------------------------------------
module dar_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [dar_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  logic [dar_pkg::CSR_DATA_W-1:0]     wr_data,
   output dar_pkg::cfg_type                   cfg
);
   import dar_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_RAMP_STEP:         cfg_in.ramp_step         = wr_data[7:0];
            CSR_STICK_DEADZONE:    cfg_in.stick_deadzone    = wr_data;
            CSR_TRIGGER_THRESHOLD: cfg_in.trigger_threshold = wr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step         <= RAMP_STEP_RST;
         cfg_ff.stick_deadzone    <= STICK_DEADZONE_RST;
         cfg_ff.trigger_threshold <= TRIGGER_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/digital_to_analog_axis_ramp_core.sv @@
// ----------------------------------------------------------------------------
// digital_to_analog_axis_ramp_core: key and pad to analog wheel and pedals
// held keys ramp the wheel and pedals; a pad stick or trigger sets them directly
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  req     | in        | req_valid/req_stall | req_payload (frame item)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_payload (axes and buttons)
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  one item per clock sustained while rsp_stall is low; an item waits in the input
//  register and its result loads into the output register once the output slot frees
//  the axis state register closes the only loop, updated as each result loads
//  a stalled output holds its result and stalls the input register behind it
//  synchronous active-high reset: empty pipeline, wheel 512, pedals 0,
//  registers at step 20, deadzone 8000, threshold 2000
//
module digital_to_analog_axis_ramp_core (
   input  logic                              clock,
   input  logic                              reset,
   // input transfers
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dar_pkg::req_payload_type          req_payload,
   // result transfers
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dar_pkg::rsp_payload_type          rsp_payload,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dar_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dar_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dar_pkg::*;

   cfg_type         cfg;

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;

   // output register
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;

   // axis state carried from frame to frame
   axis_state_type  state_ff;
   axis_state_type  state_in;
   rsp_payload_type calc_result;

   logic            out_free;
   logic            advance;
   logic            in_take;

   // configuration is always accepted
   assign csr_ready = 1'b1;

   dar_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   dar_axis_calc u_calc (
      .item       (in_data_ff),
      .cfg        (cfg),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (calc_result)
   );

   // output slot frees when empty or when its result transfers this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control and axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.wheel <= WHEEL_CENTRE;
         state_ff.fwd   <= 9'd0;
         state_ff.bwd   <= 9'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= calc_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
